// ===== hdl/ltsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltsd_pkg
// Shared types, constants and LFSR helper functions for the table stream
// decryptor.
// ----------------------------------------------------------------------------
package ltsd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TAB_AW    = 8;
  localparam int unsigned TAP_W     = 5;

  // number of table fill rounds, counted down to one
  localparam int unsigned FILL_ROUNDS = 10;
  localparam int unsigned RND_W       = $clog2(FILL_ROUNDS + 1);

  localparam logic [WORD_W-1:0] TABLE_SEED_XOR = 32'h49A5_F3C7;
  localparam logic [BYTE_W-1:0] TABLE_INIT_XOR = 8'hAB;

  localparam logic [TAP_W-1:0] FILL_TAP0 = 5'd1;
  localparam logic [TAP_W-1:0] FILL_TAP1 = 5'd15;
  localparam logic [TAP_W-1:0] FILL_TAP2 = 5'd29;

  localparam logic [TAP_W-1:0] WORD_TAP0 = 5'd6;
  localparam logic [TAP_W-1:0] WORD_TAP1 = 5'd28;
  localparam logic [TAP_W-1:0] WORD_TAP2 = 5'd30;
  localparam logic [TAP_W-1:0] BYTE_TAP0 = 5'd9;
  localparam logic [TAP_W-1:0] BYTE_TAP1 = 5'd20;
  localparam logic [TAP_W-1:0] BYTE_TAP2 = 5'd31;

  // op field codes
  localparam logic OP_WORD = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  typedef struct packed {
    logic              load;         // transaction accepted, capture payload
    logic              fresh;        // first item: seed registers from key
    logic              fill_shift;   // advance fill lfsr by eight steps
    logic              fill_read;    // read table entry idx
    logic              fill_write;   // write table entry idx
    logic              first_round;  // entry comes from its initial value
    logic [RND_W-1:0]  round;
    logic [TAB_AW-1:0] idx;
    logic              step;         // main lfsr step plus low rmw
    logic              half;         // high rmw of the current step
    logic              tab_rd;       // final table lookup
    logic [1:0]        tab_sel;      // byte of acc used as lookup address
    logic              tab_or;       // fold lookup data into result pad
    logic              finish;       // form result, load output register
  } ltsd_cmd_t;

  typedef struct packed {
    logic byte_mode;
  } ltsd_status_t;

  function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] s,
                                                  input logic [TAP_W-1:0]  a,
                                                  input logic [TAP_W-1:0]  b,
                                                  input logic [TAP_W-1:0]  c);
    lfsr_step = {s[WORD_W-2:0], s[a] ^ s[b] ^ s[c]};
  endfunction

  function automatic logic [WORD_W-1:0] lfsr_step8(input logic [WORD_W-1:0] s,
                                                   input logic [TAP_W-1:0]  a,
                                                   input logic [TAP_W-1:0]  b,
                                                   input logic [TAP_W-1:0]  c);
    logic [WORD_W-1:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      v = lfsr_step(v, a, b, c);
    end
    lfsr_step8 = v;
  endfunction

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] v;
    v = m ^ (m >> 7);
    v = v ^ (v >> 21);
    v = v ^ (v << 17);
    mix_word = v;
  endfunction

  function automatic logic [WORD_W-1:0] mix_byte(input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] v;
    v = m ^ (m >> 7);
    v = v ^ (v << 17);
    v = v ^ (v >> 21);
    mix_byte = v;
  endfunction

endpackage

// ===== hdl/ltsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltsd_ctrl
// Sequencer for table build, the 32 lfsr steps of an item, the final table
// lookups and the output register handshake.
// ----------------------------------------------------------------------------
module ltsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ltsd_pkg::ltsd_status_t status_i,
  output ltsd_pkg::ltsd_cmd_t    cmd_o
);
  import ltsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_STEP_A,
    S_STEP_B,
    S_DRAIN,
    S_TAB,
    S_FIN
  } state_e;

  localparam logic [1:0] PH_LAST        = 2'd3;
  localparam logic [2:0] TAB_READS_WORD = 3'd4;
  localparam logic [2:0] TAB_READS_BYTE = 3'd1;

  state_e            state_q;
  logic              built_q;
  logic [1:0]        ph_q;
  logic [TAB_AW-1:0] idx_q;
  logic [RND_W-1:0]  round_q;
  logic [4:0]        k_q;
  logic [2:0]        j_q;
  logic              out_valid_q;

  logic [2:0] tab_reads;
  logic       accept;

  assign tab_reads   = status_i.byte_mode ? TAB_READS_BYTE : TAB_READS_WORD;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.round       = round_q;
    cmd_o.idx         = idx_q;
    cmd_o.first_round = (round_q == RND_W'(FILL_ROUNDS));
    cmd_o.tab_sel     = j_q[1:0];
    cmd_o.load        = accept;
    cmd_o.fresh       = accept && !built_q;
    cmd_o.fill_shift  = (state_q == S_FILL);
    cmd_o.fill_read   = (state_q == S_FILL) && (ph_q == '0) && !cmd_o.first_round;
    cmd_o.fill_write  = (state_q == S_FILL) && (ph_q == PH_LAST);
    cmd_o.step        = (state_q == S_STEP_A);
    cmd_o.half        = (state_q == S_STEP_B);
    cmd_o.tab_rd      = (state_q == S_TAB) && (j_q < tab_reads);
    cmd_o.tab_or      = (state_q == S_TAB) && (j_q != '0);
    cmd_o.finish      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      built_q     <= 1'b0;
      ph_q        <= '0;
      idx_q       <= '0;
      round_q     <= '0;
      k_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            k_q <= '0;
            if (!built_q) begin
              built_q <= 1'b1;
              ph_q    <= '0;
              idx_q   <= '0;
              round_q <= RND_W'(FILL_ROUNDS);
              state_q <= S_FILL;
            end else begin
              state_q <= S_STEP_A;
            end
          end
        end
        S_FILL: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == PH_LAST) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == '1) begin
              if (round_q == RND_W'(1)) begin
                state_q <= S_STEP_A;
              end else begin
                round_q <= round_q - 1'b1;
              end
            end
          end
        end
        S_STEP_A: begin
          state_q <= S_STEP_B;
        end
        S_STEP_B: begin
          k_q <= k_q + 1'b1;
          if (k_q == '1) begin
            state_q <= S_DRAIN;
          end else begin
            state_q <= S_STEP_A;
          end
        end
        S_DRAIN: begin
          j_q     <= '0;
          state_q <= S_TAB;
        end
        S_TAB: begin
          j_q <= j_q + 1'b1;
          if (j_q == tab_reads) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // first transaction after reset always builds the table
  a_first_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !built_q |=> state_q == S_FILL)
    else $error("first transaction did not start the table build");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP_B) && (k_q == '1) |=> state_q == S_DRAIN)
    else $error("lfsr step count did not end after 32 steps");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("output valid raised outside the finish state");

endmodule

// ===== hdl/ltsd_datapath.sv =====
// ----------------------------------------------------------------------------
// ltsd_datapath
// Shift registers, accumulators, pad table memory with read-modify-write
// forwarding, and the output data register.
// ----------------------------------------------------------------------------
module ltsd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltsd_pkg::WORD_W-1:0]      cfg_wdata_i,
  input  logic                             op_i,
  input  logic [ltsd_pkg::WORD_W-1:0]      data_in_i,
  input  ltsd_pkg::ltsd_cmd_t              cmd_i,
  output ltsd_pkg::ltsd_status_t           status_o,
  output logic [ltsd_pkg::WORD_W-1:0]      data_out_o
);
  import ltsd_pkg::*;

  localparam int unsigned TAB_DEPTH = 2 ** TAB_AW;

  logic [BYTE_W-1:0] mem [TAB_DEPTH];

  logic [WORD_W-1:0] key_q;
  logic [WORD_W-1:0] s_q, m_q, acc_q, h_q, din_q, out_q;
  logic              op_q;
  logic [BYTE_W-1:0] tor_q;
  logic [BYTE_W-1:0] rd_q;

  // pending read-modify-write and the write of the previous cycle
  logic              pend_q;
  logic [TAB_AW-1:0] pa_q;
  logic [BYTE_W-1:0] pv_q;
  logic              lw_valid_q;
  logic [TAB_AW-1:0] lw_addr_q;
  logic [BYTE_W-1:0] lw_data_q;

  logic [TAP_W-1:0]  t0, t1, t2;
  logic [WORD_W-1:0] h_next, s_next, m_next, res;
  logic              rmw_issue;
  logic [TAB_AW-1:0] rmw_addr;
  logic [BYTE_W-1:0] rmw_val, rmw_old, fill_old;
  logic              re, we;
  logic [TAB_AW-1:0] ra, wa;
  logic [BYTE_W-1:0] wd;

  assign status_o.byte_mode = (op_q == OP_BYTE);
  assign data_out_o         = out_q;

  // fill lfsr taps move with the round number
  assign t0     = TAP_W'(cmd_i.round) ^ FILL_TAP0;
  assign t1     = TAP_W'(cmd_i.round) ^ FILL_TAP1;
  assign t2     = TAP_W'(cmd_i.round) ^ FILL_TAP2;
  assign h_next = lfsr_step8(h_q, t0, t1, t2);

  assign s_next = (op_q == OP_BYTE) ? lfsr_step(s_q, BYTE_TAP0, BYTE_TAP1, BYTE_TAP2)
                                    : lfsr_step(s_q, WORD_TAP0, WORD_TAP1, WORD_TAP2);

  assign rmw_issue = cmd_i.step || cmd_i.half;
  assign rmw_addr  = cmd_i.step ? s_next[7:0]  : s_q[23:16];
  assign rmw_val   = cmd_i.step ? s_next[15:8] : s_q[31:24];

  // read issued in the same cycle as a write to that entry sees stale data
  assign rmw_old  = (lw_valid_q && (lw_addr_q == pa_q)) ? lw_data_q : rd_q;
  assign fill_old = cmd_i.first_round ? (cmd_i.idx ^ TABLE_INIT_XOR) : rd_q;

  always_comb begin
    re = rmw_issue || cmd_i.fill_read || cmd_i.tab_rd;
    priority if (rmw_issue) begin
      ra = rmw_addr;
    end else if (cmd_i.fill_read) begin
      ra = cmd_i.idx;
    end else begin
      ra = acc_q[8*cmd_i.tab_sel +: 8];
    end
    we = pend_q || cmd_i.fill_write;
    if (cmd_i.fill_write) begin
      wa = cmd_i.idx;
      wd = fill_old ^ h_next[7:0];
    end else begin
      wa = pa_q;
      wd = rmw_old ^ pv_q;
    end
  end

  always_comb begin
    if (op_q == OP_BYTE) begin
      m_next = mix_byte(m_q);
      res    = {{(WORD_W-BYTE_W){1'b0}}, din_q[7:0] ^ tor_q ^ acc_q[7:0]};
    end else begin
      m_next = mix_word(m_q);
      res    = din_q ^ {{(WORD_W-BYTE_W){1'b0}}, tor_q} ^ acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      pend_q     <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      pend_q     <= rmw_issue;
      lw_valid_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q      <= rmw_addr;
    pv_q      <= rmw_val;
    lw_addr_q <= pa_q;
    lw_data_q <= wd;

    if (cmd_i.load) begin
      op_q  <= op_i;
      din_q <= data_in_i;
      acc_q <= '0;
      tor_q <= '0;
      if (cmd_i.fresh) begin
        s_q <= key_q;
        m_q <= key_q;
        h_q <= key_q ^ TABLE_SEED_XOR;
      end
    end
    if (cmd_i.fill_shift) begin
      h_q <= h_next;
    end
    if (cmd_i.step) begin
      s_q   <= s_next;
      acc_q <= acc_q ^ s_next;
      m_q   <= m_q ^ s_next;
    end
    if (cmd_i.tab_or) begin
      tor_q <= tor_q | rd_q;
    end
    if (cmd_i.finish) begin
      out_q <= res;
      m_q   <= m_next;
      s_q   <= s_q ^ m_next ^ res;
    end
  end

  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({rmw_issue, cmd_i.fill_read, cmd_i.tab_rd}))
    else $error("more than one table read requested in a cycle");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && cmd_i.fill_write))
    else $error("fill write collides with a pending read-modify-write");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tab_rd |-> !pend_q)
    else $error("table lookup while a read-modify-write is still open");

endmodule

// ===== hdl/lfsr_table_stream_decryptor.sv =====
// ----------------------------------------------------------------------------
// lfsr_table_stream_decryptor
// Plaintext-feedback stream decryptor with a 256-byte pad table.
// ----------------------------------------------------------------------------
// The first transaction after reset first builds the pad table from the key:
// 10 rounds over all 256 entries, with the fill lfsr advancing eight steps a
// cycle. Every item then runs the 32 main lfsr steps, each doing two
// read-modify-writes on the table, which has one read and one write port,
// then a drain state, the final table lookups (four for a word, one for a
// byte) and the load of the output register. A new item is accepted only
// once the previous one has loaded the output register, which waits while
// an earlier result is still held unread. The key register is sampled only
// by the first transaction after reset.
module lfsr_table_stream_decryptor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ltsd_pkg::WORD_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [ltsd_pkg::WORD_W-1:0] data_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ltsd_pkg::WORD_W-1:0] data_out_o
);
  import ltsd_pkg::*;

  ltsd_cmd_t    cmd;
  ltsd_status_t status;

  ltsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ltsd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_i),
    .data_in_i   (data_in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .data_out_o  (data_out_o)
  );

endmodule

// ===== bench/decrypt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decrypt_checker
// Watches the key port and both streams of the table stream decryptor. It
// keeps its own pad table and shift registers, predicts each plaintext word
// and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module decrypt_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ltsd_pkg::WORD_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        op_i,
  input  logic [ltsd_pkg::WORD_W-1:0] data_in_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [ltsd_pkg::WORD_W-1:0] data_out_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int PAD_ROUNDS = 10;
  localparam logic [31:0] PAD_SEED_MASK = 32'h49A5_F3C7;
  localparam logic [7:0]  PAD_INIT_MASK = 8'hAB;

  logic [31:0] key_q;
  logic [31:0] shift_q;
  logic [31:0] mix_q;
  logic [7:0]  pad_q [256];
  logic        primed_q;
  logic [31:0] plain_q [$];
  logic [31:0] plain_exp;
  logic [31:0] plain_new;
  int          fails;

  assign fail_count_o = fails;

  function automatic logic [31:0] shift_once(input logic [31:0] s, input int a,
                                             input int b, input int c);
    return {s[30:0], s[a] ^ s[b] ^ s[c]};
  endfunction

  task automatic fill_pad_table();
    logic [31:0] h;
    int r;
    h = key_q ^ PAD_SEED_MASK;
    for (int i = 0; i < 256; i++) begin
      pad_q[i] = i[7:0] ^ PAD_INIT_MASK;
    end
    for (r = PAD_ROUNDS; r >= 1; r--) begin
      for (int i = 0; i < 256; i++) begin
        for (int k = 0; k < 32; k++) begin
          h = shift_once(h, 1 ^ r, 15 ^ r, 29 ^ r);
        end
        pad_q[i] = pad_q[i] ^ h[7:0];
      end
    end
  endtask

  task automatic decrypt_one(input logic op, input logic [31:0] din,
                             output logic [31:0] plain);
    logic [31:0] s;
    logic [31:0] m;
    logic [31:0] acc;
    logic [31:0] pad_or;
    // key is only taken by the first transaction after reset
    if (!primed_q) begin
      fill_pad_table();
      shift_q  = key_q;
      mix_q    = key_q;
      primed_q = 1'b1;
    end
    s   = shift_q;
    m   = mix_q;
    acc = '0;
    for (int k = 0; k < 32; k++) begin
      if (op == ltsd_pkg::OP_BYTE) begin
        s = shift_once(s, 9, 20, 31);
      end else begin
        s = shift_once(s, 6, 28, 30);
      end
      acc = acc ^ s;
      pad_q[s[7:0]]   = pad_q[s[7:0]] ^ s[15:8];
      pad_q[s[23:16]] = pad_q[s[23:16]] ^ s[31:24];
      m = m ^ s;
    end
    if (op == ltsd_pkg::OP_BYTE) begin
      m = m ^ (m >> 7);
      m = m ^ (m << 17);
      m = m ^ (m >> 21);
      s = s ^ m;
      plain = {24'h0, din[7:0] ^ pad_q[acc[7:0]] ^ acc[7:0]};
    end else begin
      m = m ^ (m >> 7);
      m = m ^ (m >> 21);
      m = m ^ (m << 17);
      s = s ^ m;
      // or of four table bytes only reaches the low byte
      pad_or = {24'h0, pad_q[acc[7:0]] | pad_q[acc[15:8]] | pad_q[acc[23:16]]
                       | pad_q[acc[31:24]]};
      plain = din ^ pad_or ^ acc;
    end
    shift_q = s ^ plain;
    mix_q   = m;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     = '0;
      shift_q   = '0;
      mix_q     = '0;
      primed_q  = 1'b0;
      fails     = 0;
      pending_o = 0;
      plain_q.delete();
      for (int i = 0; i < 256; i++) begin
        pad_q[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        key_q = cfg_wdata_i;
      end
      // an output can only belong to an earlier transaction, so check it first
      if (out_valid_i && out_ready_i) begin
        if (plain_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected data_out, expected none, actual %h", $time,
                   data_out_i);
        end else begin
          plain_exp = plain_q.pop_front();
          if (data_out_i !== plain_exp) begin
            fails++;
            $display("%0t: data_out mismatch, expected %h, actual %h", $time,
                     plain_exp, data_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decrypt_one(op_i, data_in_i, plain_new);
        plain_q.push_back(plain_new);
      end
      pending_o = plain_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the table stream decryptor with directed and random word and byte
// transactions under random stalls on both streams, rewrites the key between
// phases, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS = 950;
  localparam int PHASE_ITEMS  = 320;
  localparam int CALM_TAIL    = 120;
  localparam int DRAIN_CYCLES = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [31:0] data_in;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] data_out;
  int          fail_count;
  int          pending;
  bit          calm;
  int          stall_left;

  lfsr_table_stream_decryptor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .data_in_i   (data_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_out_o  (data_out)
  );

  decrypt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op),
    .data_in_i    (data_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .data_out_i   (data_out),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    out_ready  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic write_key(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // let the checker count the last accepted transaction before polling pending
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // valid stays high between back-to-back transactions
  task automatic send_item(input logic item_op, input logic [31:0] item_data);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op       <= item_op;
    data_in  <= item_data;
    @(posedge clk_i);
    while (!in_ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int count, input int calm_from);
    logic [31:0] word;
    for (int i = 0; i < count; i++) begin
      calm = (i >= calm_from) || ((i / 60) % 3 == 2);
      case ($urandom_range(0, 15))
        0:       word = 32'h0;
        1:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      send_item($urandom_range(0, 1) ? ltsd_pkg::OP_BYTE : ltsd_pkg::OP_WORD, word);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    op        <= ltsd_pkg::OP_WORD;
    data_in   <= '0;
    calm      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // only the last key before the first transaction counts
    write_key(32'h0);
    write_key(32'hFFFF_FFFF);
    write_key($urandom);

    // directed: field extremes, both ops, mixed order, ignored upper byte bits
    send_item(ltsd_pkg::OP_WORD, 32'h0000_0000);
    send_item(ltsd_pkg::OP_WORD, 32'hFFFF_FFFF);
    send_item(ltsd_pkg::OP_BYTE, 32'h0000_0000);
    send_item(ltsd_pkg::OP_BYTE, 32'h0000_00FF);
    send_item(ltsd_pkg::OP_BYTE, 32'hFFFF_FF00);
    send_item(ltsd_pkg::OP_BYTE, 32'hFFFF_FFFF);
    send_item(ltsd_pkg::OP_WORD, 32'h8000_0000);
    send_item(ltsd_pkg::OP_WORD, 32'h0000_0001);
    send_item(ltsd_pkg::OP_BYTE, 32'hA5A5_A55A);
    send_item(ltsd_pkg::OP_WORD, 32'h5A5A_5A5A);
    send_item(ltsd_pkg::OP_BYTE, $urandom);
    send_item(ltsd_pkg::OP_WORD, $urandom);
    send_item(ltsd_pkg::OP_WORD, $urandom);
    send_item(ltsd_pkg::OP_BYTE, $urandom);
    in_valid <= 1'b0;
    wait_idle();

    // key written late must not disturb the running stream
    write_key(32'hFFFF_FFFF);
    send_random(PHASE_ITEMS, PHASE_ITEMS);
    wait_idle();
    write_key(32'h0);
    send_random(PHASE_ITEMS, PHASE_ITEMS);
    wait_idle();
    write_key($urandom);
    send_random(RANDOM_ITEMS - 2 * PHASE_ITEMS, RANDOM_ITEMS - 2 * PHASE_ITEMS - CALM_TAIL);

    calm = 1'b1;
    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
